// File: sv/tcrcc_pkg.sv
package tcrcc_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned MOTION_W = 2;
    localparam int unsigned CLEAR_W  = 2;

    // command codes
    localparam logic [OP_W-1:0] OP_MODE    = 3'd0;
    localparam logic [OP_W-1:0] OP_SELECT  = 3'd1;
    localparam logic [OP_W-1:0] OP_CONFIRM = 3'd2;
    localparam logic [OP_W-1:0] OP_REBOOT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MODE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOCK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HIGH  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LOW   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOSEL = 3'd6;

    // motion codes
    localparam logic [MOTION_W-1:0] MOT_NONE  = 2'd0;
    localparam logic [MOTION_W-1:0] MOT_RAISE = 2'd1;
    localparam logic [MOTION_W-1:0] MOT_LOWER = 2'd2;
    localparam logic [MOTION_W-1:0] MOT_STOP  = 2'd3;

    // data byte codes
    localparam logic [BYTE_W-1:0] VAL_MODE_AUTO   = 8'h00;
    localparam logic [BYTE_W-1:0] VAL_MODE_REMOTE = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_ISSUE      = 8'hFF;
    localparam logic [BYTE_W-1:0] CODE_CANCEL     = 8'h00;
    localparam logic [BYTE_W-1:0] CLEAR_MAX       = 8'd2;
    localparam logic [BYTE_W-1:0] BOTTOM_TAP      = 8'd1;
    localparam logic [BYTE_W-1:0] TOP_TAP_RESET   = 8'd17;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] gear_position;
        logic              lock_active;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MOTION_W-1:0] motion_cmd;
        logic                reboot_req;
        logic [CLEAR_W-1:0]  clear_req;
        logic                restart_select_timer;
        logic                in_auto_mode;
    } t_res;

endpackage

// File: sv/tcrcc_if.sv
interface tcrcc_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [tcrcc_pkg::OP_W-1:0]        op;
    logic [tcrcc_pkg::BYTE_W-1:0]      value;
    logic [tcrcc_pkg::BYTE_W-1:0]      gear_position;
    logic                              lock_active;

    modport source (output valid, op, value, gear_position, lock_active, input ready);
    modport sink   (input valid, op, value, gear_position, lock_active, output ready);
endinterface

interface tcrcc_res_if;
    logic                              valid;
    logic                              ready;
    logic [tcrcc_pkg::STATUS_W-1:0]    status;
    logic [tcrcc_pkg::MOTION_W-1:0]    motion_cmd;
    logic                              reboot_req;
    logic [tcrcc_pkg::CLEAR_W-1:0]     clear_req;
    logic                              restart_select_timer;
    logic                              in_auto_mode;

    modport source (output valid, status, motion_cmd, reboot_req, clear_req,
                    restart_select_timer, in_auto_mode, input ready);
    modport sink   (input valid, status, motion_cmd, reboot_req, clear_req,
                    restart_select_timer, in_auto_mode, output ready);
endinterface

// File: sv/tap_changer_remote_command_check_unit.sv
// Throughput: one command per cycle unless a full result register waits on o_res.ready.
// The input register and the result register form a two-stage pipeline, and the mode/selection
// state updates as a beat moves between them.
// Reset (synchronous, i_rst_n low): auto mode, no selection, top tap 17, both stages empty.
module tap_changer_remote_command_check_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcrcc_pkg::BYTE_W-1:0]  i_cfg_data,
    tcrcc_cmd_if.sink                     i_cmd,
    tcrcc_res_if.source                   o_res
);

    logic                             r_in_vld;
    tcrcc_pkg::t_cmd                  r_in;
    logic                             r_out_vld;
    tcrcc_pkg::t_res                  r_out;

    logic [tcrcc_pkg::BYTE_W-1:0]     r_top_tap;
    logic                             r_auto;
    logic                             r_pending;
    logic [tcrcc_pkg::MOTION_W-1:0]   r_motion;

    logic                             n_auto;
    logic                             n_pending;
    logic [tcrcc_pkg::MOTION_W-1:0]   n_motion;
    tcrcc_pkg::t_res                  n_res;

    logic                             advance;
    logic                             at_top;
    logic                             at_bottom;

    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || advance;

    assign at_top    = r_in.gear_position >= r_top_tap;
    assign at_bottom = r_in.gear_position == tcrcc_pkg::BOTTOM_TAP;

    always_comb begin
        n_auto    = r_auto;
        n_pending = r_pending;
        n_motion  = r_motion;
        n_res     = '0;
        case (r_in.op)
            tcrcc_pkg::OP_MODE: begin
                if (r_in.value == tcrcc_pkg::VAL_MODE_AUTO) begin
                    n_auto = 1'b1;
                end else if (r_in.value == tcrcc_pkg::VAL_MODE_REMOTE) begin
                    n_auto = 1'b0;
                end else begin
                    n_res.status = tcrcc_pkg::ST_RANGE;
                end
            end
            tcrcc_pkg::OP_SELECT: begin
                if (r_auto) begin
                    n_res.status = tcrcc_pkg::ST_MODE;
                end else if (r_in.lock_active) begin
                    n_res.status = tcrcc_pkg::ST_LOCK;
                end else if (r_in.value == 8'(tcrcc_pkg::MOT_RAISE) && at_top) begin
                    n_res.status = tcrcc_pkg::ST_HIGH;
                end else if (r_in.value == 8'(tcrcc_pkg::MOT_LOWER) && at_bottom) begin
                    n_res.status = tcrcc_pkg::ST_LOW;
                end else if (r_in.value == 8'(tcrcc_pkg::MOT_RAISE)
                          || r_in.value == 8'(tcrcc_pkg::MOT_LOWER)
                          || r_in.value == 8'(tcrcc_pkg::MOT_STOP)) begin
                    n_motion  = r_in.value[tcrcc_pkg::MOTION_W-1:0];
                    n_pending = 1'b1;
                end else begin
                    n_res.status = tcrcc_pkg::ST_RANGE;
                end
            end
            tcrcc_pkg::OP_CONFIRM: begin
                if (r_auto) begin
                    n_res.status = tcrcc_pkg::ST_MODE;
                end else if (r_in.lock_active) begin
                    n_res.status = tcrcc_pkg::ST_LOCK;
                end else if (!r_pending) begin
                    n_res.status = tcrcc_pkg::ST_NOSEL;
                end else if (at_bottom && r_motion == tcrcc_pkg::MOT_LOWER) begin
                    n_res.status = tcrcc_pkg::ST_LOW;
                end else if (at_top && r_motion == tcrcc_pkg::MOT_RAISE) begin
                    n_res.status = tcrcc_pkg::ST_HIGH;
                end else if (r_in.value == tcrcc_pkg::CODE_ISSUE
                          || r_in.value == tcrcc_pkg::CODE_CANCEL) begin
                    if (r_in.value == tcrcc_pkg::CODE_ISSUE) begin
                        n_res.motion_cmd = r_motion;
                    end
                    n_pending                  = 1'b0;
                    n_res.restart_select_timer = 1'b1;
                end else begin
                    n_res.status = tcrcc_pkg::ST_RANGE;
                end
            end
            tcrcc_pkg::OP_REBOOT: begin
                n_res.reboot_req = (r_in.value == tcrcc_pkg::CODE_ISSUE);
            end
            tcrcc_pkg::OP_CLEAR: begin
                if (r_in.value <= tcrcc_pkg::CLEAR_MAX) begin
                    n_res.clear_req = r_in.value[tcrcc_pkg::CLEAR_W-1:0] + 2'd1;
                end
            end
            default: begin
            end
        endcase
        n_res.in_auto_mode = n_auto;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_top_tap <= tcrcc_pkg::TOP_TAP_RESET;
            r_auto    <= 1'b1;
            r_pending <= 1'b0;
            r_motion  <= tcrcc_pkg::MOT_NONE;
        end else begin
            if (i_cfg_we) begin
                r_top_tap <= i_cfg_data;
            end
            if (i_cmd.ready) begin
                r_in_vld <= i_cmd.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_auto    <= n_auto;
                r_pending <= n_pending;
                r_motion  <= n_motion;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in.op            <= i_cmd.op;
            r_in.value         <= i_cmd.value;
            r_in.gear_position <= i_cmd.gear_position;
            r_in.lock_active   <= i_cmd.lock_active;
        end
        if (advance) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid                = r_out_vld;
    assign o_res.status               = r_out.status;
    assign o_res.motion_cmd           = r_out.motion_cmd;
    assign o_res.reboot_req           = r_out.reboot_req;
    assign o_res.clear_req            = r_out.clear_req;
    assign o_res.restart_select_timer = r_out.restart_select_timer;
    assign o_res.in_auto_mode         = r_out.in_auto_mode;

    a_restart_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.restart_select_timer |-> o_res.status == tcrcc_pkg::ST_OK)
        else $error("restart flagged on a refused command");

    a_motion_needs_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.motion_cmd != tcrcc_pkg::MOT_NONE
            |-> o_res.restart_select_timer && !o_res.in_auto_mode)
        else $error("motion issued without an accepted confirm in remote mode");

    a_confirm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.restart_select_timer |=> !r_pending)
        else $error("selection still pending after an accepted confirm");

    a_pending_needs_remote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_pending && n_pending |-> !r_auto)
        else $error("selection taken in auto mode");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_cmd.ready)
        else $error("input stalled while result register empty");

endmodule

// File: dv/tb_tap_changer_remote_command_check_unit.sv
module tb_tap_changer_remote_command_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // ops 5..7 carry no command and must pass through untouched
    localparam logic [tcrcc_pkg::OP_W-1:0] OP_SPARE = 3'd5;
    localparam logic [tcrcc_pkg::OP_W-1:0] OP_LAST  = 3'd7;

    localparam int unsigned NUM_PHASES       = 5;
    localparam int unsigned RANDOM_PER_PHASE = 131;
    localparam int unsigned STALL_LIMIT      = 2000;
    localparam int unsigned MAX_PRINTS       = 20;
    localparam int unsigned SETTLE_CYCLES    = 10;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tcrcc_pkg::BYTE_W-1:0]   i_cfg_data;

    tcrcc_cmd_if cmd_bus();
    tcrcc_res_if res_bus();

    tap_changer_remote_command_check_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's state
    logic [tcrcc_pkg::BYTE_W-1:0]   tap_limit;
    logic                           ctl_auto;
    logic                           ctl_armed;
    logic [tcrcc_pkg::MOTION_W-1:0] ctl_motion;

    tcrcc_pkg::t_cmd command_feed_q[$];
    tcrcc_pkg::t_res verdict_q[$];
    logic        cmd_taken = 1'b0;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_issued   = 0;
    int unsigned n_closed   = 0;
    int unsigned n_refused  = 0;
    int unsigned stall_cycles = 0;
    logic [tcrcc_pkg::BYTE_W-1:0] phase_tap [NUM_PHASES];

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH at result beat %0d: %s", $time, n_results, msg);
        end
    endtask

    function automatic tcrcc_pkg::t_res judge_command(input tcrcc_pkg::t_cmd c);
        tcrcc_pkg::t_res r;
        r = '0;
        r.status = tcrcc_pkg::ST_OK;
        case (c.op)
            tcrcc_pkg::OP_MODE: begin
                if (c.value == tcrcc_pkg::VAL_MODE_AUTO) begin
                    ctl_auto = 1'b1;
                end else if (c.value == tcrcc_pkg::VAL_MODE_REMOTE) begin
                    ctl_auto = 1'b0;
                end else begin
                    r.status = tcrcc_pkg::ST_RANGE;
                end
            end
            tcrcc_pkg::OP_SELECT: begin
                if (ctl_auto) begin
                    r.status = tcrcc_pkg::ST_MODE;
                end else if (c.lock_active) begin
                    r.status = tcrcc_pkg::ST_LOCK;
                end else if (c.value == 8'(tcrcc_pkg::MOT_RAISE)
                          && c.gear_position >= tap_limit) begin
                    r.status = tcrcc_pkg::ST_HIGH;
                end else if (c.value == 8'(tcrcc_pkg::MOT_LOWER)
                          && c.gear_position == tcrcc_pkg::BOTTOM_TAP) begin
                    r.status = tcrcc_pkg::ST_LOW;
                end else if (c.value == 8'(tcrcc_pkg::MOT_NONE)
                          || c.value > 8'(tcrcc_pkg::MOT_STOP)) begin
                    r.status = tcrcc_pkg::ST_RANGE;
                end else begin
                    ctl_motion = c.value[tcrcc_pkg::MOTION_W-1:0];
                    ctl_armed  = 1'b1;
                end
            end
            tcrcc_pkg::OP_CONFIRM: begin
                // limits are rechecked against the tap position at confirm time
                if (ctl_auto) begin
                    r.status = tcrcc_pkg::ST_MODE;
                end else if (c.lock_active) begin
                    r.status = tcrcc_pkg::ST_LOCK;
                end else if (!ctl_armed) begin
                    r.status = tcrcc_pkg::ST_NOSEL;
                end else if (c.gear_position == tcrcc_pkg::BOTTOM_TAP
                          && ctl_motion == tcrcc_pkg::MOT_LOWER) begin
                    r.status = tcrcc_pkg::ST_LOW;
                end else if (c.gear_position >= tap_limit
                          && ctl_motion == tcrcc_pkg::MOT_RAISE) begin
                    r.status = tcrcc_pkg::ST_HIGH;
                end else if (c.value == tcrcc_pkg::CODE_ISSUE
                          || c.value == tcrcc_pkg::CODE_CANCEL) begin
                    if (c.value == tcrcc_pkg::CODE_ISSUE) begin
                        r.motion_cmd = ctl_motion;
                    end
                    ctl_armed = 1'b0;
                    r.restart_select_timer = 1'b1;
                end else begin
                    r.status = tcrcc_pkg::ST_RANGE;
                end
            end
            tcrcc_pkg::OP_REBOOT: begin
                r.reboot_req = (c.value == tcrcc_pkg::CODE_ISSUE);
            end
            tcrcc_pkg::OP_CLEAR: begin
                if (c.value <= tcrcc_pkg::CLEAR_MAX) begin
                    r.clear_req = c.value[tcrcc_pkg::CLEAR_W-1:0] + 2'd1;
                end
            end
            default: ;
        endcase
        r.in_auto_mode = ctl_auto;
        return r;
    endfunction

    // tap positions around the interesting boundaries, plus anything
    function automatic logic [tcrcc_pkg::BYTE_W-1:0] pick_gear();
        case ($urandom_range(7))
            0:       return '0;
            1:       return tcrcc_pkg::BOTTOM_TAP;
            2:       return tap_limit - 8'd1;
            3:       return tap_limit;
            4:       return tap_limit + 8'd1;
            5:       return '1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_cmd(input logic [tcrcc_pkg::OP_W-1:0] op,
                             input logic [tcrcc_pkg::BYTE_W-1:0] value,
                             input logic [tcrcc_pkg::BYTE_W-1:0] gear, input logic lock);
        tcrcc_pkg::t_cmd c;
        c.op            = op;
        c.value         = value;
        c.gear_position = gear;
        c.lock_active   = lock;
        command_feed_q.push_back(c);
        n_queued++;
    endtask

    task automatic write_top_tap(input logic [tcrcc_pkg::BYTE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        tap_limit   = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // command driver
    always @(negedge i_clk) begin
        tcrcc_pkg::t_cmd nxt;
        logic [31:0]     rnd;
        logic            load;
        load = 1'b0;
        rnd  = $urandom;
        nxt  = rnd[$bits(tcrcc_pkg::t_cmd)-1:0];
        if (i_rst_n && (!cmd_bus.valid || cmd_taken)) begin
            if (command_feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt  = command_feed_q.pop_front();
                load = 1'b1;
            end
            cmd_bus.valid         <= load;
            cmd_bus.op            <= nxt.op;
            cmd_bus.value         <= nxt.value;
            cmd_bus.gear_position <= nxt.gear_position;
            cmd_bus.lock_active   <= nxt.lock_active;
        end
        res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // monitor, predictor and stall watchdog
    always @(posedge i_clk) begin
        tcrcc_pkg::t_cmd c;
        tcrcc_pkg::t_res got;
        tcrcc_pkg::t_res want;
        logic cmd_beat;
        logic res_beat;
        cmd_beat  = i_rst_n && cmd_bus.valid && cmd_bus.ready;
        res_beat  = i_rst_n && res_bus.valid && res_bus.ready;
        cmd_taken <= cmd_beat;

        if (res_beat) begin
            got.status               = res_bus.status;
            got.motion_cmd           = res_bus.motion_cmd;
            got.reboot_req           = res_bus.reboot_req;
            got.clear_req            = res_bus.clear_req;
            got.restart_select_timer = res_bus.restart_select_timer;
            got.in_auto_mode         = res_bus.in_auto_mode;
            n_results++;
            if (verdict_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = verdict_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.motion_cmd !== want.motion_cmd)
                    report_mismatch($sformatf("motion_cmd %0d, expected %0d",
                                              got.motion_cmd, want.motion_cmd));
                if (got.reboot_req !== want.reboot_req)
                    report_mismatch($sformatf("reboot_req %0b, expected %0b",
                                              got.reboot_req, want.reboot_req));
                if (got.clear_req !== want.clear_req)
                    report_mismatch($sformatf("clear_req %0d, expected %0d",
                                              got.clear_req, want.clear_req));
                if (got.restart_select_timer !== want.restart_select_timer)
                    report_mismatch($sformatf("restart_select_timer %0b, expected %0b",
                                              got.restart_select_timer,
                                              want.restart_select_timer));
                if (got.in_auto_mode !== want.in_auto_mode)
                    report_mismatch($sformatf("in_auto_mode %0b, expected %0b",
                                              got.in_auto_mode, want.in_auto_mode));
            end
        end

        if (cmd_beat) begin
            c.op            = cmd_bus.op;
            c.value         = cmd_bus.value;
            c.gear_position = cmd_bus.gear_position;
            c.lock_active   = cmd_bus.lock_active;
            want = judge_command(c);
            verdict_q.push_back(want);
            n_accepted++;
            if (want.motion_cmd != tcrcc_pkg::MOT_NONE) n_issued++;
            if (want.restart_select_timer) n_closed++;
            if (want.status != tcrcc_pkg::ST_OK) n_refused++;
        end

        stall_cycles = (cmd_beat || res_beat) ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned tally;
        logic [tcrcc_pkg::BYTE_W-1:0] code;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_data            = '0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.op            = '0;
        cmd_bus.value         = '0;
        cmd_bus.gear_position = '0;
        cmd_bus.lock_active   = 1'b0;
        res_bus.ready         = 1'b0;
        tap_limit             = tcrcc_pkg::TOP_TAP_RESET;
        ctl_auto              = 1'b1;
        ctl_armed             = 1'b0;
        ctl_motion            = tcrcc_pkg::MOT_NONE;
        src_idle_pct          = 22;
        snk_idle_pct          = 85;
        phase_tap[0]          = tcrcc_pkg::TOP_TAP_RESET;
        phase_tap[1]          = 8'd1;
        phase_tap[2]          = 8'd255;
        phase_tap[3]          = 8'd0;
        phase_tap[4]          = 8'($urandom_range(254, 2));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 2) begin
                src_idle_pct = 22;
                snk_idle_pct = 85;
            end else if (p < 4) begin
                src_idle_pct = 85;
                snk_idle_pct = 22;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_top_tap(phase_tap[p]);

            if (p == 0) begin
                // starts in auto mode, top tap 17
                queue_cmd(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_RAISE), 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_MODE, 8'hFF, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_MODE, tcrcc_pkg::VAL_MODE_REMOTE, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_RAISE), 8'd5, 1'b1);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'hFF, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_RAISE),
                          tcrcc_pkg::TOP_TAP_RESET, 1'b0);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_LOWER),
                          tcrcc_pkg::BOTTOM_TAP, 1'b0);
                // tap zero is not the bottom
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_LOWER), 8'd0, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, 8'h55, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE,
                          tcrcc_pkg::BOTTOM_TAP, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE, 8'd5, 1'b0);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_RAISE),
                          tcrcc_pkg::TOP_TAP_RESET - 8'd1, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE, 8'd200, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_CANCEL, 8'd3, 1'b0);
                queue_cmd(tcrcc_pkg::OP_SELECT, 8'(tcrcc_pkg::MOT_STOP), 8'd255, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE, 8'd255, 1'b1);
                queue_cmd(tcrcc_pkg::OP_CONFIRM, tcrcc_pkg::CODE_ISSUE, 8'd255, 1'b0);
                queue_cmd(tcrcc_pkg::OP_REBOOT, tcrcc_pkg::CODE_ISSUE, 8'd0, 1'b0);
                queue_cmd(tcrcc_pkg::OP_REBOOT, 8'hFE, 8'd0, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CLEAR, 8'd0, 8'd9, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CLEAR, 8'd1, 8'd9, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CLEAR, tcrcc_pkg::CLEAR_MAX, 8'd9, 1'b0);
                queue_cmd(tcrcc_pkg::OP_CLEAR, tcrcc_pkg::CLEAR_MAX + 8'd1, 8'd9, 1'b1);
                queue_cmd(OP_LAST, tcrcc_pkg::VAL_MODE_AUTO, 8'd0, 1'b0);
            end else begin
                tally = 0;
                while (tally < RANDOM_PER_PHASE) begin
                    if ($urandom_range(99) < 60) begin
                        // select followed by confirm, mostly in remote mode
                        if ($urandom_range(4) == 0) begin
                            queue_cmd(tcrcc_pkg::OP_MODE, tcrcc_pkg::VAL_MODE_REMOTE,
                                      pick_gear(), 1'b0);
                            tally++;
                        end
                        case ($urandom_range(9))
                            0, 1, 2, 3, 4, 5: code = tcrcc_pkg::CODE_ISSUE;
                            6, 7, 8:          code = tcrcc_pkg::CODE_CANCEL;
                            default:          code = 8'($urandom_range(255));
                        endcase
                        queue_cmd(tcrcc_pkg::OP_SELECT,
                                  8'($urandom_range(tcrcc_pkg::MOT_STOP,
                                                    tcrcc_pkg::MOT_RAISE)),
                                  pick_gear(), $urandom_range(15) == 0);
                        queue_cmd(tcrcc_pkg::OP_CONFIRM, code, pick_gear(),
                                  $urandom_range(15) == 0);
                        tally += 2;
                    end else begin
                        case ($urandom_range(9))
                            0:       code = tcrcc_pkg::VAL_MODE_AUTO;
                            1:       code = tcrcc_pkg::VAL_MODE_REMOTE;
                            2:       code = tcrcc_pkg::CLEAR_MAX;
                            3:       code = tcrcc_pkg::CLEAR_MAX + 8'd1;
                            4:       code = tcrcc_pkg::CODE_ISSUE;
                            default: code = 8'($urandom_range(255));
                        endcase
                        queue_cmd(3'($urandom_range(OP_LAST, tcrcc_pkg::OP_MODE)), code,
                                  pick_gear(), 1'($urandom_range(1)));
                        tally++;
                    end
                end
            end

            while (!(n_accepted == n_queued && n_results == n_accepted)) @(negedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (verdict_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        end
        $display("Covered %0d commands in %0d phases, top tap 17, 1, 255, 0 and %0d.",
                 n_accepted, NUM_PHASES, phase_tap[4]);
        $display("Motions issued %0d, selections closed %0d, refused %0d, mismatches %0d.",
                 n_issued, n_closed, n_refused, n_errors);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
